/* src/sis_pkg.sv */
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the indicator sweep unit
// Opcodes, register map, reset values, state encoding and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package sis_pkg;

	// Elaboration defaults
	localparam int REGION_DIVISOR_DEF = 5;
	localparam int FRACTION_BITS_DEF  = 16;

	// Field widths
	localparam int STRIP_W = 10;
	localparam int TICKS_W = 16;
	localparam int COLOR_W = 8;
	localparam int POS_W   = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Opcodes of an input beat
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_STRIP_LEN = 3'd0;
	localparam logic [2:0] REG_PERIOD    = 3'd1;
	localparam logic [2:0] REG_FADE_IN   = 3'd2;
	localparam logic [2:0] REG_RED       = 3'd3;
	localparam logic [2:0] REG_GREEN     = 3'd4;
	localparam logic [2:0] REG_BLUE      = 3'd5;

	// Register reset values
	localparam logic [STRIP_W-1:0] RST_STRIP_LEN = 10'd60;
	localparam logic [TICKS_W-1:0] RST_PERIOD    = 16'd1200;
	localparam logic [TICKS_W-1:0] RST_FADE_IN   = 16'd250;
	localparam logic [COLOR_W-1:0] RST_RED       = 8'd255;
	localparam logic [COLOR_W-1:0] RST_GREEN     = 8'd120;
	localparam logic [COLOR_W-1:0] RST_BLUE      = 8'd0;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEOM,
		ST_SETUP,
		ST_FDIV,
		ST_PROD,
		ST_NUM,
		ST_QDIV,
		ST_COLOR,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic geom;
		logic setup;
		logic fdiv_start;
		logic fdiv_take;
		logic prod;
		logic num;
		logic qdiv_start;
		logic qdiv_take;
		logic color;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_query;
		logic hit;
		logic fade_div;
		logic fac_div;
		logic div_done;
	} stat_t;

endpackage

/* src/sis_div.sv */
// ----------------------------------------------------------------------------
// sis_div: radix-2 restoring divider
// Produces FB quotient bits, one per cycle, from a starting remainder that
// is already below the divisor and FB low dividend bits.
// ----------------------------------------------------------------------------
module sis_div #(
	parameter int FB = sis_pkg::FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sis_pkg::TICKS_W-1:0] rem_init,
	input  logic [FB-1:0]              dividend,
	input  logic [sis_pkg::TICKS_W-1:0] divisor,
	output logic                       done,
	output logic [FB-1:0]              quot
);
	localparam int DW = sis_pkg::TICKS_W;
	localparam int CW = $clog2(FB + 1);

	logic [DW-1:0] rem_q;
	logic [FB-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// One restoring step
	assign trial = {rem_q, quo_q[FB-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(FB);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[FB-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* src/sis_dp.sv */
// ----------------------------------------------------------------------------
// sis_dp: indicator sweep datapath
// Holds the indicator flags and phases, computes region geometry, fade and
// brightness factor with a shared divider, and owns the result register.
// ----------------------------------------------------------------------------
module sis_dp #(
	parameter int REGION_DIVISOR = sis_pkg::REGION_DIVISOR_DEF,
	parameter int FRACTION_BITS  = sis_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sis_pkg::cmd_t               cmd,
	output sis_pkg::stat_t              stat,
	input  logic [1:0]                  opcode,
	input  logic                        side_sel,
	input  logic                        turn_on,
	input  logic [sis_pkg::POS_W-1:0]   region_pos,
	input  logic [sis_pkg::STRIP_W-1:0] strip_length,
	input  logic [sis_pkg::TICKS_W-1:0] blink_period_ms,
	input  logic [sis_pkg::TICKS_W-1:0] fade_in_ms,
	input  logic [sis_pkg::COLOR_W-1:0] base_red,
	input  logic [sis_pkg::COLOR_W-1:0] base_green,
	input  logic [sis_pkg::COLOR_W-1:0] base_blue,
	output logic [sis_pkg::STRIP_W-1:0] led_index,
	output logic [sis_pkg::COLOR_W-1:0] red,
	output logic [sis_pkg::COLOR_W-1:0] green,
	output logic [sis_pkg::COLOR_W-1:0] blue,
	output logic                        drawn
);
	localparam int FB  = FRACTION_BITS;
	localparam int SW  = sis_pkg::STRIP_W;
	localparam int TW  = sis_pkg::TICKS_W;
	localparam int CLW = sis_pkg::COLOR_W;
	localparam int PW  = FB + 1 + SW;
	// Reciprocal of the region divisor, exact for every 10-bit strip length
	localparam int RS    = 20;
	localparam int RECIP = ((1 << RS) + REGION_DIVISOR - 1) / REGION_DIVISOR;
	localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};

	// Indicator state
	logic          lon_q, ron_q;
	logic [TW-1:0] lphase_q, rphase_q;

	// Item registers
	logic          side_q;
	logic [SW-1:0] pos_q;
	logic [SW-1:0] rlen_q;
	logic          hit_q;
	logic [SW-1:0] idx_q, k_q, m_q;
	logic [FB:0]   f_q, fac_q;
	logic [PW-1:0] prod_q;
	logic [CLW-1:0] r_q, g_q, b_q;

	// Result register
	logic [SW-1:0]  led_index_q;
	logic [CLW-1:0] red_q, green_q, blue_q;
	logic           drawn_q;

	// Divider
	logic          div_start;
	logic [TW-1:0] div_rem;
	logic [FB-1:0] div_low;
	logic [TW-1:0] div_dvs;
	logic          div_done;
	logic [FB-1:0] div_quot;

	logic [2*SW+RS-1:0] geo_prod;
	logic [TW:0]    lnext, rnext;
	logic [TW-1:0]  ladv, radv;
	logic           me_on, other_on;
	logic [TW-1:0]  other_ph, new_ph;
	logic [TW-1:0]  ph_sel;
	logic           act, hit, fade_zero, fade_full;
	logic [PW-1:0]  kone, num;
	logic [SW:0]    num_hi;
	logic [SW-1:0]  dvs;
	logic           at_rim, under, big;
	logic [FB:0]    fac_direct;
	logic [FB+CLW:0] r_prod, g_prod, b_prod;

	// Phase advance with wrap at the period
	assign lnext = {1'b0, lphase_q} + 1'b1;
	assign rnext = {1'b0, rphase_q} + 1'b1;
	assign ladv  = (lnext >= {1'b0, blink_period_ms}) ? '0 : lnext[TW-1:0];
	assign radv  = (rnext >= {1'b0, blink_period_ms}) ? '0 : rnext[TW-1:0];

	// Switch on or off: sync to the other indicator when it runs
	assign me_on    = side_sel ? ron_q : lon_q;
	assign other_on = side_sel ? lon_q : ron_q;
	assign other_ph = side_sel ? lphase_q : rphase_q;
	assign new_ph   = (turn_on && other_on) ? other_ph : '0;

	// Apply tick and set beats at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_q    <= 1'b0;
			ron_q    <= 1'b0;
			lphase_q <= '0;
			rphase_q <= '0;
		end else if (cmd.take) begin
			case (opcode)
				sis_pkg::OP_TICK: begin
					if (lon_q) lphase_q <= ladv;
					if (ron_q) rphase_q <= radv;
				end
				sis_pkg::OP_SET: begin
					if (me_on != turn_on) begin
						if (side_sel) begin
							ron_q    <= turn_on;
							rphase_q <= new_ph;
						end else begin
							lon_q    <= turn_on;
							lphase_q <= new_ph;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Region length by reciprocal multiply
	assign geo_prod = (2*SW+RS)'(strip_length) * (2*SW+RS)'(RECIP);

	// Query qualification and fade selection
	assign ph_sel    = side_q ? rphase_q : lphase_q;
	assign act       = side_q ? ron_q : lon_q;
	assign hit       = act && (rlen_q > SW'(1)) && (pos_q < rlen_q);
	assign fade_zero = ph_sel >= (blink_period_ms >> 1);
	assign fade_full = ph_sel >= fade_in_ms;

	// Factor numerator and shortcut cases
	assign kone       = PW'({k_q, {FB{1'b0}}});
	assign at_rim     = k_q >= m_q;
	assign under      = prod_q < kone;
	assign num        = prod_q - kone;
	assign num_hi     = num[PW-1:FB];
	assign dvs        = m_q - k_q;
	assign big        = num_hi >= {1'b0, dvs};
	assign fac_direct = at_rim ? ((f_q == ONE_Q) ? ONE_Q : '0)
	                           : (under ? '0 : ONE_Q);

	// Color scaling
	assign r_prod = (FB+CLW+1)'(base_red)   * (FB+CLW+1)'(fac_q);
	assign g_prod = (FB+CLW+1)'(base_green) * (FB+CLW+1)'(fac_q);
	assign b_prod = (FB+CLW+1)'(base_blue)  * (FB+CLW+1)'(fac_q);

	// Steer the shared divider
	assign div_start = cmd.fdiv_start | cmd.qdiv_start;
	assign div_rem   = cmd.qdiv_start ? TW'(num_hi) : ph_sel;
	assign div_low   = cmd.qdiv_start ? num[FB-1:0] : '0;
	assign div_dvs   = cmd.qdiv_start ? TW'(dvs) : fade_in_ms;

	sis_div #(.FB(FB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dividend (div_low),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Step through one query
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			side_q <= side_sel;
			pos_q  <= SW'(region_pos);
		end
		if (cmd.geom) begin
			rlen_q <= geo_prod[RS+SW-1:RS];
		end
		if (cmd.setup) begin
			hit_q <= hit;
			m_q   <= rlen_q - SW'(1);
			k_q   <= side_q ? pos_q : (rlen_q - SW'(1) - pos_q);
			idx_q <= side_q ? (strip_length - rlen_q + pos_q) : pos_q;
			f_q   <= fade_zero ? '0 : ONE_Q;
		end
		if (cmd.fdiv_take) begin
			f_q <= {1'b0, div_quot};
		end
		if (cmd.prod) begin
			prod_q <= PW'(f_q) * PW'(m_q);
		end
		if (cmd.num) begin
			fac_q <= fac_direct;
		end
		if (cmd.qdiv_take) begin
			fac_q <= {1'b0, div_quot};
		end
		if (cmd.color) begin
			r_q <= r_prod[FB+CLW-1:FB];
			g_q <= g_prod[FB+CLW-1:FB];
			b_q <= b_prod[FB+CLW-1:FB];
		end
		if (cmd.load) begin
			led_index_q <= hit_q ? idx_q : '0;
			red_q       <= hit_q ? r_q : '0;
			green_q     <= hit_q ? g_q : '0;
			blue_q      <= hit_q ? b_q : '0;
			drawn_q     <= hit_q;
		end
	end

	// Status back to the controller
	always_comb begin
		stat.is_query = (opcode == sis_pkg::OP_QUERY);
		stat.hit      = hit;
		stat.fade_div = hit && !fade_zero && !fade_full;
		stat.fac_div  = !at_rim && !under && !big;
		stat.div_done = div_done;
	end

	assign led_index = led_index_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign drawn     = drawn_q;

endmodule

/* src/sis_ctrl.sv */
// ----------------------------------------------------------------------------
// sis_ctrl: indicator sweep controller
// Sequences one beat at a time through the datapath and tracks the result
// register's valid flag.
// ----------------------------------------------------------------------------
module sis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output logic           result_valid,
	input  logic           result_ready,
	input  sis_pkg::stat_t stat,
	output sis_pkg::cmd_t  cmd
);
	sis_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            free;

	assign free = !out_valid_q || result_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sis_pkg::ST_IDLE: begin
				if (item_valid && stat.is_query) state_d = sis_pkg::ST_GEOM;
			end
			sis_pkg::ST_GEOM: begin
				state_d = sis_pkg::ST_SETUP;
			end
			sis_pkg::ST_SETUP: begin
				if (!stat.hit)         state_d = sis_pkg::ST_OUT;
				else if (stat.fade_div) state_d = sis_pkg::ST_FDIV;
				else                   state_d = sis_pkg::ST_PROD;
			end
			sis_pkg::ST_FDIV: begin
				if (stat.div_done) state_d = sis_pkg::ST_PROD;
			end
			sis_pkg::ST_PROD: begin
				state_d = sis_pkg::ST_NUM;
			end
			sis_pkg::ST_NUM: begin
				state_d = stat.fac_div ? sis_pkg::ST_QDIV : sis_pkg::ST_COLOR;
			end
			sis_pkg::ST_QDIV: begin
				if (stat.div_done) state_d = sis_pkg::ST_COLOR;
			end
			sis_pkg::ST_COLOR: begin
				state_d = sis_pkg::ST_OUT;
			end
			sis_pkg::ST_OUT: begin
				if (free) state_d = sis_pkg::ST_IDLE;
			end
			default: begin
				state_d = sis_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			sis_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.take   = item_valid;
			end
			sis_pkg::ST_GEOM:  cmd.geom = 1'b1;
			sis_pkg::ST_SETUP: begin
				cmd.setup      = 1'b1;
				cmd.fdiv_start = stat.fade_div;
			end
			sis_pkg::ST_FDIV:  cmd.fdiv_take = stat.div_done;
			sis_pkg::ST_PROD:  cmd.prod = 1'b1;
			sis_pkg::ST_NUM: begin
				cmd.num        = 1'b1;
				cmd.qdiv_start = stat.fac_div;
			end
			sis_pkg::ST_QDIV:  cmd.qdiv_take = stat.div_done;
			sis_pkg::ST_COLOR: cmd.color = 1'b1;
			sis_pkg::ST_OUT:   cmd.load = free;
			default: ;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sis_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)        out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

/* src/sequential_indicator_sweep_unit.sv */
// ----------------------------------------------------------------------------
// sequential_indicator_sweep_unit: left/right LED turn indicator sweep
// Keeps two blinking indicators in phase and answers pixel queries with the
// faded color of one LED in the indicator's region of the strip.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries one beat: a millisecond
//   tick, an on/off set for one side, or a pixel query. Only a query yields
//   a result beat on the output channel (result_valid/result_ready).
//   Tick and set beats are applied as they are taken. A query takes two
//   passes of the bit-serial divider, one quotient bit per cycle, for the
//   fade ramp and the brightness factor; passes are skipped when the fade
//   or factor is zero or full.
//   A finished result sits in the output register; while the receiver
//   stalls, further tick and set beats are still taken, and a new query
//   waits in its last step until the register frees.
//   Reset clears both indicators to off with phase 0, empties the output
//   register and loads the register defaults; there is no clearing pass.
//   User must write registers via APB port with no beat in flight; unenforced.
// ----------------------------------------------------------------------------
module sequential_indicator_sweep_unit #(
	parameter int REGION_DIVISOR = sis_pkg::REGION_DIVISOR_DEF,
	parameter int FRACTION_BITS  = sis_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sis_pkg::ADDR_W-1:0]  paddr,
	input  logic [sis_pkg::DATA_W-1:0]  pwdata,
	output logic [sis_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// Input channel
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  opcode,
	input  logic                        side_sel,
	input  logic                        turn_on,
	input  logic [sis_pkg::POS_W-1:0]   region_pos,
	// Result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [sis_pkg::STRIP_W-1:0] led_index,
	output logic [sis_pkg::COLOR_W-1:0] red,
	output logic [sis_pkg::COLOR_W-1:0] green,
	output logic [sis_pkg::COLOR_W-1:0] blue,
	output logic                        drawn
);
	localparam int DW = sis_pkg::DATA_W;

	logic [sis_pkg::STRIP_W-1:0] strip_length_q;
	logic [sis_pkg::TICKS_W-1:0] period_q;
	logic [sis_pkg::TICKS_W-1:0] fade_in_q;
	logic [sis_pkg::COLOR_W-1:0] red_cfg_q, green_cfg_q, blue_cfg_q;
	logic [2:0]                  reg_idx;
	logic                        wr_en;

	sis_pkg::cmd_t  cmd;
	sis_pkg::stat_t stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sis_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_length_q <= sis_pkg::RST_STRIP_LEN;
			period_q       <= sis_pkg::RST_PERIOD;
			fade_in_q      <= sis_pkg::RST_FADE_IN;
			red_cfg_q      <= sis_pkg::RST_RED;
			green_cfg_q    <= sis_pkg::RST_GREEN;
			blue_cfg_q     <= sis_pkg::RST_BLUE;
		end else if (wr_en) begin
			case (reg_idx)
				sis_pkg::REG_STRIP_LEN: strip_length_q <= pwdata[sis_pkg::STRIP_W-1:0];
				sis_pkg::REG_PERIOD:    period_q       <= pwdata[sis_pkg::TICKS_W-1:0];
				sis_pkg::REG_FADE_IN:   fade_in_q      <= pwdata[sis_pkg::TICKS_W-1:0];
				sis_pkg::REG_RED:       red_cfg_q      <= pwdata[sis_pkg::COLOR_W-1:0];
				sis_pkg::REG_GREEN:     green_cfg_q    <= pwdata[sis_pkg::COLOR_W-1:0];
				sis_pkg::REG_BLUE:      blue_cfg_q     <= pwdata[sis_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			sis_pkg::REG_STRIP_LEN: prdata = DW'(strip_length_q);
			sis_pkg::REG_PERIOD:    prdata = DW'(period_q);
			sis_pkg::REG_FADE_IN:   prdata = DW'(fade_in_q);
			sis_pkg::REG_RED:       prdata = DW'(red_cfg_q);
			sis_pkg::REG_GREEN:     prdata = DW'(green_cfg_q);
			sis_pkg::REG_BLUE:      prdata = DW'(blue_cfg_q);
			default:                prdata = '0;
		endcase
	end

	sis_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	sis_dp #(
		.REGION_DIVISOR (REGION_DIVISOR),
		.FRACTION_BITS  (FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.side_sel        (side_sel),
		.turn_on         (turn_on),
		.region_pos      (region_pos),
		.strip_length    (strip_length_q),
		.blink_period_ms (period_q),
		.fade_in_ms      (fade_in_q),
		.base_red        (red_cfg_q),
		.base_green      (green_cfg_q),
		.base_blue       (blue_cfg_q),
		.led_index       (led_index),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.drawn           (drawn)
	);

endmodule

/* src/sis_checker.sv */
// ----------------------------------------------------------------------------
// sis_checker: port-level checks for the indicator sweep unit
// Watches the result channel and config port and is bound to the top level.
// ----------------------------------------------------------------------------
module sis_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [sis_pkg::STRIP_W-1:0] led_index,
	input logic [sis_pkg::COLOR_W-1:0] red,
	input logic [sis_pkg::COLOR_W-1:0] green,
	input logic [sis_pkg::COLOR_W-1:0] blue,
	input logic                        drawn,
	input logic                        pready
);
	// Hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(led_index)
		&& $stable(red) && $stable(green) && $stable(blue) && $stable(drawn))
		else $error("stalled result beat changed");

	// An undrawn pixel carries all-zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !drawn |-> led_index == '0 && red == '0
		&& green == '0 && blue == '0)
		else $error("undrawn result has nonzero fields");

	// A result never appears right after an input beat was taken
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_valid && item_ready))
		else $error("result too soon after accepted beat");

	// Config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind sequential_indicator_sweep_unit sis_checker u_sis_checker (.*);
